[hw/rtl/sts_pkg.sv]
package sts_pkg;

    // field widths of the token position counters
    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    // result queue depth, a power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    // keyword buffer depth and number of keywords
    localparam int KW_CHARS = 6;
    localparam int KW_COUNT = 16;

    typedef logic [4:0] kind_t;

    // token kinds
    localparam kind_t K_IDENT   = 5'd16;
    localparam kind_t K_INTEGER = 5'd17;
    localparam kind_t K_STRING  = 5'd18;
    localparam kind_t K_COMMA   = 5'd19;
    localparam kind_t K_SEMI    = 5'd20;
    localparam kind_t K_LPAREN  = 5'd21;
    localparam kind_t K_RPAREN  = 5'd22;
    localparam kind_t K_STAR    = 5'd23;
    localparam kind_t K_EQ      = 5'd24;
    localparam kind_t K_NE      = 5'd25;
    localparam kind_t K_LT      = 5'd26;
    localparam kind_t K_LE      = 5'd27;
    localparam kind_t K_GT      = 5'd28;
    localparam kind_t K_GE      = 5'd29;
    localparam kind_t K_EOF     = 5'd30;
    localparam kind_t K_BAD     = 5'd31;

    // character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LESS   = "<";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_DASH   = "-";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_STAR   = "*";

    // keyword text, left justified, first character in the top byte
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
        "select",
        {"from", 16'h0},
        {"where", 8'h0},
        "insert",
        {"into", 16'h0},
        "create",
        {"table", 8'h0},
        "values",
        {"int", 24'h0},
        {"text", 16'h0},
        {"and", 24'h0},
        {"or", 32'h0},
        {"not", 24'h0},
        {"null", 16'h0},
        {"true", 16'h0},
        {"false", 8'h0}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd4, 3'd5, 3'd6, 3'd4, 3'd6, 3'd5, 3'd6,
        3'd3, 3'd4, 3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5
    };

    typedef enum logic [3:0] {
        M_IDLE,
        M_WORD,
        M_DIGITS,
        M_STR,
        M_STRQ,
        M_LT,
        M_GT,
        M_BANG,
        M_DASH,
        M_REM
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } scan_req_t;

    typedef struct packed {
        kind_t                  token_kind;
        logic [OFFSET_BITS-1:0] token_offset;
        logic [OFFSET_BITS-1:0] token_length;
        logic [LINE_BITS-1:0]   token_line;
        logic [COLUMN_BITS-1:0] token_column;
        logic                   last_of_run;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } token_pair_t;

    typedef struct packed {
        scan_mode_t             scan_mode;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [LINE_BITS-1:0]   line_number;
        logic [COLUMN_BITS-1:0] column_number;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [LINE_BITS-1:0]   start_line;
        logic [COLUMN_BITS-1:0] start_column;
        logic [2:0]             word_length;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        scan_mode:     M_IDLE,
        byte_offset:   '0,
        line_number:   LINE_BITS'(1),
        column_number: COLUMN_BITS'(1),
        start_offset:  '0,
        start_line:    LINE_BITS'(1),
        start_column:  COLUMN_BITS'(1),
        word_length:   3'd0
    };

endpackage

[hw/rtl/sql_token_scanner_top.sv]
// channel  | signals                               | payload
// request  | byte_valid, byte_stall, byte_item     | sts_pkg::scan_req_t
// result   | token_valid, token_stall, token_item  | sts_pkg::token_t
//
// one request per cycle while byte_stall is low; the scan state updates at the
// accepting edge and its tokens (zero, one or two) appear in the result queue
// from the next cycle; the four-entry result queue drains one token per cycle
// while token_stall is low; since one request can make two tokens, the request
// side stalls while the queue has under two free slots; reset clears the scan state
// and empties the queue; end of input returns the scan state to its reset value
module sql_token_scanner_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  sts_pkg::scan_req_t byte_item,
    output logic               token_valid,
    input  logic               token_stall,
    output sts_pkg::token_t    token_item
);

    sts_pkg::scan_state_t               state_reg, state_next;
    logic [sts_pkg::KW_CHARS-1:0][7:0]  kbuf_reg, kbuf_next;
    sts_pkg::token_pair_t               tokens;
    logic                               full;
    logic                               accept;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    // per-byte scan logic
    sts_step u_step
    (
        .state      (state_reg),
        .kbuf       (kbuf_reg),
        .req        (byte_item),
        .state_next (state_next),
        .kbuf_next  (kbuf_next),
        .tokens     (tokens)
    );

    // scan state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sts_pkg::SCAN_RESET;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // keyword buffer, read only after written
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kbuf_reg <= kbuf_next;
        end
    end

    // result queue
    sts_out_queue u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (accept),
        .tokens      (tokens),
        .full        (full),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_item  (token_item)
    );

endmodule

[hw/rtl/sts_step.sv]
module sts_step
(
    input  sts_pkg::scan_state_t state,
    input  logic [sts_pkg::KW_CHARS-1:0][7:0] kbuf,
    input  sts_pkg::scan_req_t   req,
    output sts_pkg::scan_state_t state_next,
    output logic [sts_pkg::KW_CHARS-1:0][7:0] kbuf_next,
    output sts_pkg::token_pair_t tokens
);

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0" && c <= "9");
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    logic [7:0]                      b;
    logic [sts_pkg::OFFSET_BITS-1:0] next_offset;
    sts_pkg::kind_t                  word_kind;
    logic                            hit;

    logic                            pend_en;
    sts_pkg::kind_t                  pend_kind;
    logic [sts_pkg::OFFSET_BITS-1:0] pend_end;
    logic                            run_idle;

    logic                            b_en;
    sts_pkg::kind_t                  b_kind;
    logic [sts_pkg::OFFSET_BITS-1:0] b_len;

    sts_pkg::token_t                 pend_tok;
    sts_pkg::token_t                 b_tok;

    assign b = req.byte_value;
    assign next_offset = (state.byte_offset == '1) ? state.byte_offset
                                                   : state.byte_offset + 1'b1;

    // keyword match on the buffered lowercase bytes
    always_comb
    begin
        word_kind = sts_pkg::K_IDENT;
        hit = 1'b0;
        for (int k = sts_pkg::KW_COUNT - 1; k >= 0; k--)
        begin
            hit = (sts_pkg::KW_LEN[k] == state.word_length);
            for (int i = 0; i < sts_pkg::KW_CHARS; i++)
            begin
                if (3'(i) < state.word_length &&
                    kbuf[i] != sts_pkg::KW_TEXT[k][8*(sts_pkg::KW_CHARS-i)-1 -: 8])
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                word_kind = 5'(k);
            end
        end
    end

    // mode transition for one request
    always_comb
    begin
        state_next = state;
        kbuf_next  = kbuf;
        pend_en    = 1'b0;
        pend_kind  = sts_pkg::K_BAD;
        pend_end   = state.byte_offset;
        run_idle   = 1'b0;
        b_en       = 1'b0;
        b_kind     = sts_pkg::K_BAD;
        b_len      = next_offset - state.byte_offset;

        if (req.end_of_input)
        begin
            // flush pending token, then end of file at the current position
            unique case (state.scan_mode)
                sts_pkg::M_WORD:
                begin
                    pend_en = 1'b1;
                    pend_kind = word_kind;
                end
                sts_pkg::M_DIGITS:
                begin
                    pend_en = 1'b1;
                    pend_kind = sts_pkg::K_INTEGER;
                end
                sts_pkg::M_STRQ:
                begin
                    pend_en = 1'b1;
                    pend_kind = sts_pkg::K_STRING;
                end
                sts_pkg::M_LT:
                begin
                    pend_en = 1'b1;
                    pend_kind = sts_pkg::K_LT;
                end
                sts_pkg::M_GT:
                begin
                    pend_en = 1'b1;
                    pend_kind = sts_pkg::K_GT;
                end
                sts_pkg::M_STR, sts_pkg::M_BANG, sts_pkg::M_DASH:
                begin
                    pend_en = 1'b1;
                    pend_kind = sts_pkg::K_BAD;
                end
                default:
                begin
                    pend_en = 1'b0;
                end
            endcase
            b_en = 1'b1;
            b_kind = sts_pkg::K_EOF;
            b_len = '0;
            state_next = sts_pkg::SCAN_RESET;
        end
        else
        begin
            unique case (state.scan_mode)
                sts_pkg::M_WORD:
                begin
                    if (is_alpha(b) || is_digit(b) || b == sts_pkg::CH_UNDER)
                    begin
                        if (state.word_length < 3'(sts_pkg::KW_CHARS))
                        begin
                            kbuf_next[state.word_length] = to_lower(b);
                        end
                        if (state.word_length != 3'd7)
                        begin
                            state_next.word_length = state.word_length + 3'd1;
                        end
                    end
                    else
                    begin
                        pend_en = 1'b1;
                        pend_kind = word_kind;
                        run_idle = 1'b1;
                    end
                end
                sts_pkg::M_DIGITS:
                begin
                    if (!is_digit(b))
                    begin
                        pend_en = 1'b1;
                        pend_kind = sts_pkg::K_INTEGER;
                        run_idle = 1'b1;
                    end
                end
                sts_pkg::M_STR:
                begin
                    if (b == sts_pkg::CH_QUOTE)
                    begin
                        state_next.scan_mode = sts_pkg::M_STRQ;
                    end
                end
                sts_pkg::M_STRQ:
                begin
                    if (b == sts_pkg::CH_QUOTE)
                    begin
                        state_next.scan_mode = sts_pkg::M_STR;
                    end
                    else
                    begin
                        pend_en = 1'b1;
                        pend_kind = sts_pkg::K_STRING;
                        run_idle = 1'b1;
                    end
                end
                sts_pkg::M_LT:
                begin
                    pend_en = 1'b1;
                    if (b == sts_pkg::CH_EQ || b == sts_pkg::CH_GT)
                    begin
                        pend_kind = (b == sts_pkg::CH_EQ) ? sts_pkg::K_LE : sts_pkg::K_NE;
                        pend_end = next_offset;
                        state_next.scan_mode = sts_pkg::M_IDLE;
                    end
                    else
                    begin
                        pend_kind = sts_pkg::K_LT;
                        run_idle = 1'b1;
                    end
                end
                sts_pkg::M_GT, sts_pkg::M_BANG:
                begin
                    pend_en = 1'b1;
                    if (b == sts_pkg::CH_EQ)
                    begin
                        pend_kind = (state.scan_mode == sts_pkg::M_GT) ? sts_pkg::K_GE
                                                                       : sts_pkg::K_NE;
                        pend_end = next_offset;
                        state_next.scan_mode = sts_pkg::M_IDLE;
                    end
                    else
                    begin
                        pend_kind = (state.scan_mode == sts_pkg::M_GT) ? sts_pkg::K_GT
                                                                       : sts_pkg::K_BAD;
                        run_idle = 1'b1;
                    end
                end
                sts_pkg::M_DASH:
                begin
                    if (b == sts_pkg::CH_DASH)
                    begin
                        state_next.scan_mode = sts_pkg::M_REM;
                    end
                    else
                    begin
                        pend_en = 1'b1;
                        pend_kind = sts_pkg::K_BAD;
                        run_idle = 1'b1;
                    end
                end
                sts_pkg::M_REM:
                begin
                    if (b == sts_pkg::CH_LF)
                    begin
                        state_next.scan_mode = sts_pkg::M_IDLE;
                    end
                end
                default:
                begin
                    run_idle = 1'b1;
                end
            endcase

            // scan the byte from idle
            if (run_idle)
            begin
                state_next.scan_mode = sts_pkg::M_IDLE;
                if (!(b == sts_pkg::CH_SPACE || b == sts_pkg::CH_TAB ||
                      b == sts_pkg::CH_LF || b == sts_pkg::CH_CR))
                begin
                    state_next.start_offset = state.byte_offset;
                    state_next.start_line   = state.line_number;
                    state_next.start_column = state.column_number;
                    priority if (is_alpha(b) || b == sts_pkg::CH_UNDER)
                    begin
                        kbuf_next[0] = to_lower(b);
                        state_next.word_length = 3'd1;
                        state_next.scan_mode = sts_pkg::M_WORD;
                    end
                    else if (is_digit(b))
                    begin
                        state_next.scan_mode = sts_pkg::M_DIGITS;
                    end
                    else if (b == sts_pkg::CH_QUOTE)
                    begin
                        state_next.scan_mode = sts_pkg::M_STR;
                    end
                    else if (b == sts_pkg::CH_LESS)
                    begin
                        state_next.scan_mode = sts_pkg::M_LT;
                    end
                    else if (b == sts_pkg::CH_GT)
                    begin
                        state_next.scan_mode = sts_pkg::M_GT;
                    end
                    else if (b == sts_pkg::CH_BANG)
                    begin
                        state_next.scan_mode = sts_pkg::M_BANG;
                    end
                    else if (b == sts_pkg::CH_DASH)
                    begin
                        state_next.scan_mode = sts_pkg::M_DASH;
                    end
                    else
                    begin
                        b_en = 1'b1;
                        priority if (b == sts_pkg::CH_COMMA)  b_kind = sts_pkg::K_COMMA;
                        else if (b == sts_pkg::CH_SEMI)       b_kind = sts_pkg::K_SEMI;
                        else if (b == sts_pkg::CH_LPAREN)     b_kind = sts_pkg::K_LPAREN;
                        else if (b == sts_pkg::CH_RPAREN)     b_kind = sts_pkg::K_RPAREN;
                        else if (b == sts_pkg::CH_STAR)       b_kind = sts_pkg::K_STAR;
                        else if (b == sts_pkg::CH_EQ)         b_kind = sts_pkg::K_EQ;
                        else                                  b_kind = sts_pkg::K_BAD;
                    end
                end
            end

            // position counters, saturating
            state_next.byte_offset = next_offset;
            if (b == sts_pkg::CH_LF)
            begin
                if (state.line_number != '1)
                begin
                    state_next.line_number = state.line_number + 1'b1;
                end
                state_next.column_number = sts_pkg::COLUMN_BITS'(1);
            end
            else if (state.column_number != '1)
            begin
                state_next.column_number = state.column_number + 1'b1;
            end
        end
    end

    // token assembly
    always_comb
    begin
        pend_tok.token_kind   = pend_kind;
        pend_tok.token_offset = state.start_offset;
        pend_tok.token_length = pend_end - state.start_offset;
        pend_tok.token_line   = state.start_line;
        pend_tok.token_column = state.start_column;
        pend_tok.last_of_run  = !b_en;

        b_tok.token_kind   = b_kind;
        b_tok.token_offset = state.byte_offset;
        b_tok.token_length = b_len;
        b_tok.token_line   = state.line_number;
        b_tok.token_column = state.column_number;
        b_tok.last_of_run  = 1'b1;

        tokens.count  = {1'b0, pend_en} + {1'b0, b_en};
        tokens.first  = pend_en ? pend_tok : b_tok;
        tokens.second = b_tok;
    end

endmodule

[hw/rtl/sts_out_queue.sv]
module sts_out_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sts_pkg::token_pair_t tokens,
    output logic                 full,
    output logic                 token_valid,
    input  logic                 token_stall,
    output sts_pkg::token_t      token_item
);

    sts_pkg::token_t                    mem [sts_pkg::QUEUE_DEPTH];
    logic [sts_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sts_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sts_pkg::QUEUE_PTR_BITS:0]   count_reg, count_next;
    logic [1:0]                         wr_num;
    logic                               pop;

    // room for two tokens is needed before a request is taken
    assign full        = count_reg > (sts_pkg::QUEUE_PTR_BITS+1)'(sts_pkg::QUEUE_DEPTH - 2);
    assign token_valid = count_reg != '0;
    assign token_item  = mem[rd_ptr_reg];
    assign pop         = token_valid && !token_stall;
    assign wr_num      = push ? tokens.count : 2'd0;

    // pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + sts_pkg::QUEUE_PTR_BITS'(wr_num);
        rd_ptr_next = rd_ptr_reg + sts_pkg::QUEUE_PTR_BITS'(pop);
        count_next  = count_reg + (sts_pkg::QUEUE_PTR_BITS+1)'(wr_num)
                      - (sts_pkg::QUEUE_PTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token storage
    always_ff @(posedge clk)
    begin
        if (wr_num != 2'd0)
        begin
            mem[wr_ptr_reg] <= tokens.first;
        end
        if (wr_num == 2'd2)
        begin
            mem[wr_ptr_reg + 1'b1] <= tokens.second;
        end
    end

endmodule
